[hw/rtl/ftad_pkg.sv]
// Shared types, constants and the division step for the fat tree address decoder.
// Used by ftad_cell and fat_tree_address_decoder_unit.
`default_nettype none
package ftad_pkg;

    localparam int MAX_DEPTH      = 8;
    localparam int ADDR_W         = 32;
    localparam int STEPS_PER_CELL = 4;
    localparam int CELLS_PER_LVL  = ADDR_W / STEPS_PER_CELL;
    localparam int NUM_CELLS      = MAX_DEPTH * CELLS_PER_LVL;

    typedef enum logic [2:0] {
        REG_TREE_DEPTH  = 3'd0,
        REG_TOP_DOWN    = 3'd1,
        REG_MID_DOWN    = 3'd2,
        REG_MID_UP      = 3'd3,
        REG_RACK_DOWN   = 3'd4,
        REG_RACK_UP     = 3'd5,
        REG_OWN_ADDRESS = 3'd6
    } t_reg_index;

    // One long division in flight: dividend bits leave the top of word,
    // quotient bits enter at the bottom.
    typedef struct packed {
        logic [ADDR_W-1:0] word;
        logic [7:0]        rem;
    } t_lane;

    typedef struct packed {
        logic       valid;
        logic [2:0] query_level;
        logic [3:0] match_depth;
        logic [7:0] level_index;
        logic [7:0] path_digit;
        logic       same_subtree;
        t_lane      dst;
        t_lane      own;
        t_lane      pth;
    } t_item;

    // Per-level setup handed to the cells of that level
    typedef struct packed {
        logic [7:0] down_div;
        logic [3:0] down_level;
        logic       down_active;
        logic [7:0] up_div;
        logic [3:0] up_level;
        logic       up_active;
    } t_level_cfg;

    function automatic t_lane ftad_divide(input t_lane a, input logic [7:0] div);
        t_lane      r;
        logic [8:0] part;
        r = a;
        for (int s = 0; s < STEPS_PER_CELL; s++) begin
            part   = {r.rem, r.word[ADDR_W-1]};
            r.word = {r.word[ADDR_W-2:0], 1'b0};
            if (part >= {1'b0, div}) begin
                part      = part - {1'b0, div};
                r.word[0] = 1'b1;
            end
            r.rem = part[7:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/fat_tree_address_decoder_unit.sv]
// Fat tree mixed-radix address decoder, top level.
// Holds the configuration registers and the chain of ftad_cell; depends on ftad_pkg.
//
// Usage:
//   s_axis carries one query per transaction; tdata holds dest_address,
//   path_number, query_level, match_depth. m_axis returns one result per
//   query; tdata holds level_index, path_digit, same_subtree, address_in_range.
//   The tree shape and own address are written through i_cfg_we/index/data
//   while no query is in flight.
// Timing:
//   A query passes 64 cells (8 levels x 8 cells, 4 division steps per cell,
//   32 steps per level divide), the first capturing it at the accepting edge,
//   then the output register. Throughput is one query per cycle while
//   m_axis is not stalled; each cell hands its item on when the chain is enabled.
// Reset:
//   Synchronous, active low; clears all valid bits and loads the default
//   three-level radix-4 tree with own address 0.
// Backpressure:
//   When m_axis_tready is low with a result waiting, the whole chain holds
//   and s_axis_tready drops; nothing is lost or repeated.
`default_nettype none
module fat_tree_address_decoder_unit
    import ftad_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] dest_address, [63:32] path_number, [66:64] query_level,
    // [70:67] match_depth, [71] zero
    input  wire  [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] level_index, [15:8] path_digit, [16] same_subtree,
    // [17] address_in_range, [23:18] zero
    output logic [23:0] m_axis_tdata,
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [31:0] i_cfg_data
);

    logic [3:0]        r_tree_depth;
    logic [7:0]        r_top_down;
    logic [7:0]        r_mid_down;
    logic [7:0]        r_mid_up;
    logic [7:0]        r_rack_down;
    logic [7:0]        r_rack_up;
    logic [ADDR_W-1:0] r_own_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_depth  <= 4'd3;
            r_top_down    <= 8'd4;
            r_mid_down    <= 8'd4;
            r_mid_up      <= 8'd4;
            r_rack_down   <= 8'd4;
            r_rack_up     <= 8'd4;
            r_own_address <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_index'(i_cfg_index))
                REG_TREE_DEPTH:  r_tree_depth  <= i_cfg_data[3:0];
                REG_TOP_DOWN:    r_top_down    <= i_cfg_data[7:0];
                REG_MID_DOWN:    r_mid_down    <= i_cfg_data[7:0];
                REG_MID_UP:      r_mid_up      <= i_cfg_data[7:0];
                REG_RACK_DOWN:   r_rack_down   <= i_cfg_data[7:0];
                REG_RACK_UP:     r_rack_up     <= i_cfg_data[7:0];
                REG_OWN_ADDRESS: r_own_address <= i_cfg_data[ADDR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic [3:0] depth;
    logic [7:0] top_down_nz, mid_down_nz, mid_up_nz, rack_down_nz, rack_up_nz;

    always_comb begin
        depth = r_tree_depth;
        if (depth < 4'd2) depth = 4'd2;
        if (depth > 4'(MAX_DEPTH)) depth = 4'(MAX_DEPTH);
        top_down_nz  = (r_top_down  == 8'd0) ? 8'd1 : r_top_down;
        mid_down_nz  = (r_mid_down  == 8'd0) ? 8'd1 : r_mid_down;
        mid_up_nz    = (r_mid_up    == 8'd0) ? 8'd1 : r_mid_up;
        rack_down_nz = (r_rack_down == 8'd0) ? 8'd1 : r_rack_down;
        rack_up_nz   = (r_rack_up   == 8'd0) ? 8'd1 : r_rack_up;
    end

    // Chain slot k divides the address by the radix of level depth-1-k
    // (lowest digit first) and the path by the radix of level k+1.
    t_level_cfg lvl_cfg [MAX_DEPTH];

    for (genvar k = 0; k < MAX_DEPTH; k++) begin : g_lvl
        localparam logic [3:0] K = 4'(k);
        always_comb begin
            lvl_cfg[k].down_active = K < depth;
            lvl_cfg[k].down_level  = depth - 4'd1 - K;
            if (!lvl_cfg[k].down_active) begin
                lvl_cfg[k].down_div = 8'd1;
            end else if (K == 4'd0) begin
                lvl_cfg[k].down_div = rack_down_nz;
            end else if (lvl_cfg[k].down_level == 4'd0) begin
                lvl_cfg[k].down_div = top_down_nz;
            end else begin
                lvl_cfg[k].down_div = mid_down_nz;
            end
            lvl_cfg[k].up_level  = K + 4'd1;
            lvl_cfg[k].up_active = lvl_cfg[k].up_level < depth;
            if (!lvl_cfg[k].up_active) begin
                lvl_cfg[k].up_div = 8'd1;
            end else if (lvl_cfg[k].up_level == depth - 4'd1) begin
                lvl_cfg[k].up_div = rack_up_nz;
            end else begin
                lvl_cfg[k].up_div = mid_up_nz;
            end
        end
    end

    logic  chain_en;
    t_item chain [NUM_CELLS+1];

    assign chain_en      = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = chain_en;

    always_comb begin
        chain[0].valid        = s_axis_tvalid;
        chain[0].query_level  = s_axis_tdata[66:64];
        chain[0].match_depth  = s_axis_tdata[70:67];
        chain[0].level_index  = '0;
        chain[0].path_digit   = '0;
        chain[0].same_subtree = 1'b1;
        chain[0].dst.word     = s_axis_tdata[31:0];
        chain[0].dst.rem      = '0;
        chain[0].own.word     = r_own_address;
        chain[0].own.rem      = '0;
        chain[0].pth.word     = s_axis_tdata[63:32];
        chain[0].pth.rem      = '0;
    end

    for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
        ftad_cell #(
            .LAST (c % CELLS_PER_LVL == CELLS_PER_LVL - 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (chain_en),
            .i_cfg   (lvl_cfg[c / CELLS_PER_LVL]),
            .i_item  (chain[c]),
            .o_item  (chain[c+1])
        );
    end

    t_item last_item;
    assign last_item = chain[NUM_CELLS];

    logic        r_out_valid;
    logic [23:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (chain_en) begin
            r_out_valid <= last_item.valid;
        end
    end

    // address is in range when nothing is left after dividing by every radix
    always_ff @(posedge i_clk) begin
        if (chain_en) begin
            r_out_data <= {6'd0, (last_item.dst.word == '0), last_item.same_subtree,
                           last_item.path_digit, last_item.level_index};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef SYNTH
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_match_zero_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_item.valid && last_item.match_depth == 4'd0 |-> last_item.same_subtree)
        else $error("empty match depth must report same subtree");

    a_top_path_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_item.valid && last_item.query_level == 3'd0 |-> last_item.path_digit == 8'd0)
        else $error("path digit at top level must be zero");
`endif

endmodule
`default_nettype wire

[hw/rtl/ftad_cell.sv]
// One cell of the decode chain: a few restoring division steps on three lanes.
// The last cell of a level also picks up the level's digits. Depends on ftad_pkg.
`default_nettype none
module ftad_cell
    import ftad_pkg::*;
#(
    parameter bit LAST = 1'b0
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_en,
    input  t_level_cfg i_cfg,
    input  t_item      i_item,
    output t_item      o_item
);

    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item     = i_item;
        n_item.dst = ftad_divide(i_item.dst, i_cfg.down_div);
        n_item.own = ftad_divide(i_item.own, i_cfg.down_div);
        n_item.pth = ftad_divide(i_item.pth, i_cfg.up_div);
        if (LAST) begin
            if (i_cfg.down_active) begin
                if (i_cfg.down_level == {1'b0, i_item.query_level}) begin
                    n_item.level_index = n_item.dst.rem;
                end
                if (i_cfg.down_level < i_item.match_depth &&
                    n_item.dst.rem != n_item.own.rem) begin
                    n_item.same_subtree = 1'b0;
                end
            end
            if (i_cfg.up_active &&
                i_cfg.up_level == {1'b0, i_item.query_level}) begin
                n_item.path_digit = n_item.pth.rem;
            end
            // quotient moves on as the next level's dividend
            n_item.dst.rem = '0;
            n_item.own.rem = '0;
            n_item.pth.rem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.valid <= 1'b0;
        end else if (i_en) begin
            r_item <= n_item;
        end
    end

    assign o_item = r_item;

endmodule
`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for fat_tree_address_decoder_unit.
// Predicts each decode from the mixed-radix tree shape; depends on ftad_pkg and the RTL.
`default_nettype none
module tb;
    import ftad_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [31:0] dest_address, [63:32] path_number, [66:64] query_level,
    // [70:67] match_depth, [71] zero
    logic [71:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] level_index, [15:8] path_digit, [16] same_subtree, [17] address_in_range
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    fat_tree_address_decoder_unit dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the configuration registers
    logic [3:0]  sh_depth;
    logic [7:0]  sh_top_down, sh_mid_down, sh_mid_up, sh_rack_down, sh_rack_up;
    logic [31:0] sh_own;

    logic [23:0] decode_q[$];
    int          errors = 0;
    bit          rx_hold = 1'b0;
    bit          rx_random = 1'b1;

    function automatic logic [7:0] nz(input logic [7:0] v);
        return (v == 0) ? 8'd1 : v;
    endfunction

    // digit of value at level: (value / prod) % radix; big prod gives 0
    function automatic logic [23:0] decode_ref(input logic [31:0] dest, input logic [31:0] pth,
                                               input logic [2:0] lvl, input logic [3:0] mdep);
        int unsigned d, m;
        logic [63:0] dn[MAX_DEPTH], up[MAX_DEPTH];
        logic [63:0] below[MAX_DEPTH+1], above[MAX_DEPTH];
        bit          bbig[MAX_DEPTH+1], abig[MAX_DEPTH];
        logic [63:0] ld, pd, a, b;
        bit          same;
        bit          inr;
        d = (sh_depth < 2) ? 2 : (sh_depth > MAX_DEPTH ? MAX_DEPTH : sh_depth);
        for (int i = 0; i < MAX_DEPTH; i++) begin
            dn[i] = nz(sh_mid_down);
            up[i] = nz(sh_mid_up);
        end
        dn[0] = nz(sh_top_down);
        up[0] = 1;
        dn[d-1] = nz(sh_rack_down);
        up[d-1] = nz(sh_rack_up);
        below[d] = 1; bbig[d] = 0;
        for (int i = d; i > 0; i--) begin
            bbig[i-1] = bbig[i] || (below[i] > 64'hFFFF_FFFF_FFFF_FFFF / dn[i-1]);
            below[i-1] = bbig[i-1] ? '1 : below[i] * dn[i-1];
        end
        above[0] = 1; abig[0] = 0;
        for (int i = 1; i < d; i++) begin
            abig[i] = abig[i-1] || (above[i-1] > 64'hFFFF_FFFF_FFFF_FFFF / up[i]);
            above[i] = abig[i] ? '1 : above[i-1] * up[i];
        end
        m = (mdep > d) ? d : mdep;
        same = 1'b1;
        for (int i = 0; i < m; i++) begin
            a = bbig[i+1] ? 0 : (64'(dest) / below[i+1]) % dn[i];
            b = bbig[i+1] ? 0 : (64'(sh_own) / below[i+1]) % dn[i];
            if (a != b) same = 1'b0;
        end
        inr = bbig[0] || (64'(dest) < below[0]);
        ld = (lvl >= d || bbig[lvl+1]) ? 0 : (64'(dest) / below[lvl+1]) % dn[lvl];
        pd = (lvl == 0 || lvl >= d || abig[lvl-1]) ? 0 : (64'(pth) / above[lvl-1]) % up[lvl];
        return {6'd0, inr, same, pd[7:0], ld[7:0]};
    endfunction

    task automatic write_reg(input t_reg_index idx, input logic [31:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_TREE_DEPTH:  sh_depth     = val[3:0];
            REG_TOP_DOWN:    sh_top_down  = val[7:0];
            REG_MID_DOWN:    sh_mid_down  = val[7:0];
            REG_MID_UP:      sh_mid_up    = val[7:0];
            REG_RACK_DOWN:   sh_rack_down = val[7:0];
            REG_RACK_UP:     sh_rack_up   = val[7:0];
            REG_OWN_ADDRESS: sh_own       = val;
            default: ;
        endcase
    endtask

    task automatic set_tree(input logic [3:0] dep, input logic [7:0] td, input logic [7:0] md,
                            input logic [7:0] mu, input logic [7:0] rd, input logic [7:0] ru,
                            input logic [31:0] own);
        write_reg(REG_TREE_DEPTH, 32'(dep));
        write_reg(REG_TOP_DOWN, 32'(td));
        write_reg(REG_MID_DOWN, 32'(md));
        write_reg(REG_MID_UP, 32'(mu));
        write_reg(REG_RACK_DOWN, 32'(rd));
        write_reg(REG_RACK_UP, 32'(ru));
        write_reg(REG_OWN_ADDRESS, own);
    endtask

    // tvalid stays high after a transaction; a gap before the next query, or drain(), drops it
    task automatic send_query(input logic [31:0] dest, input logic [31:0] pth,
                              input logic [2:0] lvl, input logic [3:0] mdep, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 9) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, mdep, lvl, pth, dest};
        decode_q.push_back(decode_ref(dest, pth, lvl, mdep));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (decode_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (70) @(posedge i_clk);
    endtask

    // keep each query mostly within the tree so deep digits get exercised
    task automatic random_queries(input int n);
        logic [31:0] dest;
        for (int k = 0; k < n; k++) begin
            dest = $urandom();
            if ($urandom_range(0, 2) != 0) dest = dest & ($urandom_range(0, 1) ? 32'hFF : 32'hFFFF);
            if ($urandom_range(0, 4) == 0) dest = sh_own ^ (32'd1 << $urandom_range(0, 31));
            send_query(dest, $urandom(), 3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), 1);
        end
    endtask

    task automatic test_reset_tree();
        // default shape: 64 servers, radix 4 everywhere
        for (int l = 0; l < 8; l++)
            send_query(32'd27 + l, 32'hFFFF_FFFF, 3'(l), 4'(l), 0);
        send_query(32'd63, 32'd0, 3'd2, 4'd3, 0);
        send_query(32'd64, 32'd15, 3'd1, 4'd0, 0);
        send_query(32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 4'd15, 0);
        send_query(32'd0, 32'd0, 3'd0, 4'd8, 0);
        drain();
    endtask

    task automatic test_shapes();
        // zero counts, depth clamps, overflowing products, odd radices
        set_tree(4'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 32'd0);
        for (int k = 0; k < 6; k++)
            send_query($urandom(), $urandom(), 3'(k), 4'(k), 0);
        drain();
        set_tree(4'd15, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 32'hFFFF_FFFF);
        for (int k = 0; k < 8; k++)
            send_query(32'hFFFF_FFFF - k, 32'hFFFF_FFFF, 3'(k), 4'(k + 1), 0);
        drain();
        set_tree(4'd8, 8'd1, 8'd2, 8'd3, 8'd5, 8'd7, 32'h0000_0155);
        random_queries(150);
        drain();
    endtask

    task automatic test_random_shapes();
        for (int p = 0; p < 9; p++) begin
            set_tree(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom_range(0, 16)),
                     8'($urandom), 8'($urandom_range(0, 16)), 8'($urandom), $urandom());
            random_queries(120);
            drain();
        end
    endtask

    task automatic test_backpressure();
        // receiver stalls long while the sender streams; then sender waits for all results
        set_tree(4'd3, 8'd4, 8'd4, 8'd4, 8'd4, 8'd4, 32'd5);
        rx_random = 1'b0;
        rx_hold = 1'b1;
        fork
            for (int k = 0; k < 120; k++)
                send_query($urandom() & 32'h3F, $urandom(), 3'($urandom_range(0, 7)),
                           4'($urandom_range(0, 8)), 0);
            begin
                repeat (300) @(posedge i_clk);
                rx_hold = 1'b0;
            end
        join
        rx_random = 1'b1;
        drain();
        random_queries(200);
        drain();
    endtask

    // receiver: random stalls per result, off while a long hold is forced
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            wait_cycles = rx_random ? $urandom_range(0, 9) : 0;
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (wait_cycles != 0 || rx_hold) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cycles) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge i_clk) begin
        logic [23:0] exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (decode_q.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_axis_tdata);
                errors++;
            end else begin
                exp_r = decode_q.pop_front();
                if (m_axis_tdata[7:0] !== exp_r[7:0]) begin
                    $display("%0t level_index exp %0d got %0d", $time, exp_r[7:0],
                             m_axis_tdata[7:0]);
                    errors++;
                end
                if (m_axis_tdata[15:8] !== exp_r[15:8]) begin
                    $display("%0t path_digit exp %0d got %0d", $time, exp_r[15:8],
                             m_axis_tdata[15:8]);
                    errors++;
                end
                if (m_axis_tdata[16] !== exp_r[16]) begin
                    $display("%0t same_subtree exp %0b got %0b", $time, exp_r[16],
                             m_axis_tdata[16]);
                    errors++;
                end
                if (m_axis_tdata[17] !== exp_r[17]) begin
                    $display("%0t address_in_range exp %0b got %0b", $time, exp_r[17],
                             m_axis_tdata[17]);
                    errors++;
                end
            end
        end
    end

    initial begin
        sh_depth = 4'd3; sh_top_down = 8'd4; sh_mid_down = 8'd4; sh_mid_up = 8'd4;
        sh_rack_down = 8'd4; sh_rack_up = 8'd4; sh_own = 32'd0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_tree();
        test_shapes();
        test_backpressure();
        test_random_shapes();
        if (errors == 0 && decode_q.size() == 0)
            $display("fat_tree_address_decoder_unit: match");
        else
            $display("fat_tree_address_decoder_unit: mismatch");
        $finish;
    end

    initial begin
        #800000;
        $display("fat_tree_address_decoder_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
